/* rtl/dllc_pkg.sv */
// Package for the directory listing line checker.
// Holds parse position codes, verdict codes, character constants and
// character-class helpers. No dependencies.
package dllc_pkg;

    // Parse position codes
    localparam logic [4:0] POS_TYPE      = 5'd0;
    localparam logic [4:0] POS_PERM0     = 5'd1;
    localparam logic [4:0] POS_PERM1     = 5'd2;
    localparam logic [4:0] POS_PERM2     = 5'd3;
    localparam logic [4:0] POS_PERM3     = 5'd4;
    localparam logic [4:0] POS_PERM4     = 5'd5;
    localparam logic [4:0] POS_PERM5     = 5'd6;
    localparam logic [4:0] POS_PERM6     = 5'd7;
    localparam logic [4:0] POS_PERM7     = 5'd8;
    localparam logic [4:0] POS_PERM8     = 5'd9;
    localparam logic [4:0] POS_BLANK1    = 5'd10;
    localparam logic [4:0] POS_BLANKS1   = 5'd11;
    localparam logic [4:0] POS_AFTERZERO = 5'd12;
    localparam logic [4:0] POS_DIGITS    = 5'd13;
    localparam logic [4:0] POS_BLANKS2   = 5'd14;
    localparam logic [4:0] POS_NAME      = 5'd15;
    localparam logic [4:0] POS_EOL       = 5'd16;

    // Verdict codes
    localparam logic [1:0] V_OK    = 2'd0;
    localparam logic [1:0] V_MATCH = 2'd1;
    localparam logic [1:0] V_REJ   = 2'd2;

    // Characters
    localparam logic [7:0] CH_D_LO   = 8'h64; // 'd'
    localparam logic [7:0] CH_D_UP   = 8'h44; // 'D'
    localparam logic [7:0] CH_B      = 8'h62; // 'b'
    localparam logic [7:0] CH_C      = 8'h63; // 'c'
    localparam logic [7:0] CH_P      = 8'h70; // 'p'
    localparam logic [7:0] CH_S      = 8'h73; // 's'
    localparam logic [7:0] CH_DASH   = 8'h2d; // '-'
    localparam logic [7:0] CH_R      = 8'h72; // 'r'
    localparam logic [7:0] CH_W      = 8'h77; // 'w'
    localparam logic [7:0] CH_X      = 8'h78; // 'x'
    localparam logic [7:0] CH_STAR   = 8'h2a; // '*'
    localparam logic [7:0] CH_SLASH  = 8'h2f; // '/'
    localparam logic [7:0] CH_NL     = 8'h0a; // newline
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_A_UP   = 8'h41;
    localparam logic [7:0] CH_Z_UP   = 8'h5a;
    localparam logic [7:0] CH_A_LO   = 8'h61;
    localparam logic [7:0] CH_Z_LO   = 8'h7a;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_UNDER  = 8'h5f;

    // Result of one parse step
    typedef struct packed {
        logic [4:0] next_pos;
        logic [1:0] verdict;
    } step_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_name_start(input logic [7:0] c);
        return ((c >= CH_A_UP) && (c <= CH_Z_UP)) ||
               ((c >= CH_A_LO) && (c <= CH_Z_LO)) ||
               (c == CH_DOT) || (c == CH_UNDER);
    endfunction

endpackage

/* rtl/dllc_step.sv */
// Combinational parse step of the directory listing line checker.
// Maps the current parse position and one character to the next position
// and a verdict. Depends on dllc_pkg.
module dllc_step (
    input  logic [4:0]     pos,
    input  logic [7:0]     ch,
    output dllc_pkg::step_t step
);
    import dllc_pkg::*;

    logic [4:0] nxt;
    logic [1:0] vrd;
    logic       rej;
    logic [7:0] perm_letter;

    // Letter expected at each permission slot (rwx repeating)
    always_comb
    begin
        case (pos)
            POS_PERM0, POS_PERM3, POS_PERM6: perm_letter = CH_R;
            POS_PERM1, POS_PERM4, POS_PERM7: perm_letter = CH_W;
            default:                         perm_letter = CH_X;
        endcase
    end

    // Grammar transition
    always_comb
    begin
        nxt = POS_TYPE;
        vrd = V_OK;
        rej = 1'b0;
        unique case (pos) inside
            POS_TYPE:
            begin
                if (ch == CH_D_LO || ch == CH_D_UP || ch == CH_B || ch == CH_C ||
                    ch == CH_P || ch == CH_S || ch == CH_DASH)
                    nxt = POS_PERM0;
                else
                    rej = 1'b1;
            end
            [POS_PERM0:POS_PERM8]:
            begin
                if (ch == perm_letter || ch == CH_DASH)
                    nxt = pos + 5'd1;
                else
                    rej = 1'b1;
            end
            POS_BLANK1:
            begin
                if (is_blank(ch)) nxt = POS_BLANKS1;
                else              rej = 1'b1;
            end
            POS_BLANKS1:
            begin
                if (is_blank(ch))       nxt = POS_BLANKS1;
                else if (ch == CH_ZERO) nxt = POS_AFTERZERO;
                else if (is_digit(ch))  nxt = POS_DIGITS;
                else                    rej = 1'b1;
            end
            POS_AFTERZERO:
            begin
                if (is_blank(ch)) nxt = POS_BLANKS2;
                else              rej = 1'b1;
            end
            POS_DIGITS:
            begin
                if (is_blank(ch))      nxt = POS_BLANKS2;
                else if (is_digit(ch)) nxt = POS_DIGITS;
                else                   rej = 1'b1;
            end
            POS_BLANKS2:
            begin
                if (is_blank(ch))           nxt = POS_BLANKS2;
                else if (is_name_start(ch)) nxt = POS_NAME;
                else                        rej = 1'b1;
            end
            POS_NAME:
            begin
                if (is_name_start(ch) || is_digit(ch))  nxt = POS_NAME;
                else if (ch == CH_STAR || ch == CH_SLASH) nxt = POS_EOL;
                else if (ch == CH_NL)                   vrd = V_MATCH;
                else                                    rej = 1'b1;
            end
            POS_EOL:
            begin
                if (ch == CH_NL) vrd = V_MATCH;
                else             rej = 1'b1;
            end
            default: rej = 1'b1;
        endcase
        // Rejection restarts the line
        if (rej)
        begin
            vrd = V_REJ;
            nxt = POS_TYPE;
        end
    end

    assign step.next_pos = nxt;
    assign step.verdict  = vrd;

endmodule

/* rtl/directory_listing_line_checker.sv */
// Directory listing line checker, top level.
// Input stage, parse position register and result register; uses dllc_step
// and dllc_pkg.
//
// Usage:
//   Characters of a long-format listing line enter on the src channel
//   (byte_in, src_valid/src_ready), one byte per transaction. For each byte
//   one verdict leaves on the res channel (verdict, res_valid/res_ready):
//   0 line still valid so far, 1 line matched at newline, 2 line rejected.
//   After a match or a rejection the next byte starts a new line.
//   Pipeline: a byte accepted on src sits in the input register, then its
//   verdict moves to the result register, from which the res transaction
//   completes; a stall on res can hold it in either register.
//   Throughput: one byte per cycle unless res stalls; the parse position
//   update is a single small transition between input and result registers.
//   Stall: when res_ready is low the result register holds, the input
//   register fills, and src_ready drops only when both are occupied.
//   Reset: rst_n clears both valid flags and returns the parse position to
//   the type-letter position.
module directory_listing_line_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       src_valid,
    output logic       src_ready,
    input  logic [7:0] byte_in,
    output logic       res_valid,
    input  logic       res_ready,
    output logic [1:0] verdict
);
    import dllc_pkg::*;

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic [4:0] pos_reg;
    logic [4:0] pos_next;
    logic       out_valid_reg;
    logic [1:0] verdict_reg;
    logic       s1_advance;
    step_t      step;

    // Flow control: result register frees up when empty or taken
    assign s1_advance = !out_valid_reg || res_ready;
    assign src_ready  = !s1_valid_reg || s1_advance;

    dllc_step u_step (
        .pos  (pos_reg),
        .ch   (s1_byte_reg),
        .step (step)
    );

    assign pos_next = (s1_valid_reg && s1_advance) ? step.next_pos : pos_reg;

    // Input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (src_ready)
            s1_valid_reg <= src_valid;
    end

    always_ff @(posedge clk)
    begin
        if (src_ready && src_valid)
            s1_byte_reg <= byte_in;
    end

    // Parse position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= POS_TYPE;
        else
            pos_reg <= pos_next;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_advance)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_valid_reg)
            verdict_reg <= step.verdict;
    end

    assign res_valid = out_valid_reg;
    assign verdict   = verdict_reg;

`ifndef SYNTH
    // Any finished line restarts the parser
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_advance && step.verdict != V_OK) |=> pos_reg == POS_TYPE)
        else $error("parse position not reset after match or reject");

    // Position never leaves the defined range
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_EOL)
        else $error("parse position out of range");

    // A match only comes from a newline at the name or suffix position
    a_match_src: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && step.verdict == V_MATCH) |->
        ((pos_reg == POS_NAME || pos_reg == POS_EOL) && s1_byte_reg == CH_NL))
        else $error("match outside name or suffix position");

    // Position only moves when an item leaves the input stage
    a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(s1_valid_reg && s1_advance) |=> $stable(pos_reg))
        else $error("parse position changed without a transaction");

    // Empty input stage always takes a byte
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> src_ready)
        else $error("input stage empty but not ready");
`endif

endmodule

/* tb/tb.sv */
// Testbench for directory_listing_line_checker: drives listing lines byte by byte
// and checks every verdict against an in-bench parser of the line grammar.
// Depends on dllc_pkg and the directory_listing_line_checker RTL.
`timescale 1ns / 1ps

module tb;

    import dllc_pkg::*;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       src_valid = 1'b0;
    logic       src_ready;
    logic [7:0] byte_in   = 8'h00;
    logic       res_valid;
    logic       res_ready = 1'b0;
    logic [1:0] verdict;

    // Grammar position of the line being parsed, and verdicts still to come
    logic [4:0] line_pos = POS_TYPE;
    logic [1:0] pending_verdicts[$];

    // Idle controls for the two sides
    bit src_idle = 1'b0;
    bit rcv_idle = 1'b0;

    int bytes_sent     = 0;
    int verdicts_seen  = 0;
    int lines_matched  = 0;
    int lines_rejected = 0;
    int error_count    = 0;

    directory_listing_line_checker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .byte_in   (byte_in),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .verdict   (verdict)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("directory_listing_line_checker: mismatch");
        $finish;
    end

    // Parse one character: advance line_pos and return the verdict it gives
    function automatic logic [1:0] parse_char(input logic [7:0] ch);
        logic       blank;
        logic       digit;
        logic       name_char;
        logic [7:0] perm_letter;
        logic [4:0] nxt;
        logic [1:0] v;
        blank     = (ch == CH_SPACE) || (ch == CH_TAB);
        digit     = (ch >= CH_ZERO) && (ch <= CH_NINE);
        name_char = ((ch >= CH_A_UP) && (ch <= CH_Z_UP)) ||
                    ((ch >= CH_A_LO) && (ch <= CH_Z_LO)) ||
                    (ch == CH_DOT) || (ch == CH_UNDER);
        nxt = POS_TYPE;
        v   = V_REJ;
        if (line_pos == POS_TYPE)
        begin
            if (ch == CH_D_LO || ch == CH_D_UP || ch == CH_B || ch == CH_C ||
                ch == CH_P || ch == CH_S || ch == CH_DASH)
            begin
                nxt = POS_PERM0;
                v   = V_OK;
            end
        end
        else if (line_pos >= POS_PERM0 && line_pos < POS_BLANK1)
        begin
            // permissions cycle through r, w, x
            case ((line_pos - POS_PERM0) % 3)
                0:       perm_letter = CH_R;
                1:       perm_letter = CH_W;
                default: perm_letter = CH_X;
            endcase
            if (ch == perm_letter || ch == CH_DASH)
            begin
                nxt = line_pos + 5'd1;
                v   = V_OK;
            end
        end
        else if (line_pos == POS_BLANK1)
        begin
            if (blank)
            begin
                nxt = POS_BLANKS1;
                v   = V_OK;
            end
        end
        else if (line_pos == POS_BLANKS1)
        begin
            if (blank || digit)
            begin
                v   = V_OK;
                nxt = blank ? POS_BLANKS1 : (ch == CH_ZERO) ? POS_AFTERZERO : POS_DIGITS;
            end
        end
        else if (line_pos == POS_AFTERZERO)
        begin
            if (blank)
            begin
                nxt = POS_BLANKS2;
                v   = V_OK;
            end
        end
        else if (line_pos == POS_DIGITS)
        begin
            if (blank || digit)
            begin
                nxt = blank ? POS_BLANKS2 : POS_DIGITS;
                v   = V_OK;
            end
        end
        else if (line_pos == POS_BLANKS2)
        begin
            if (blank || name_char)
            begin
                nxt = blank ? POS_BLANKS2 : POS_NAME;
                v   = V_OK;
            end
        end
        else if (line_pos == POS_NAME)
        begin
            if (name_char || digit)
            begin
                nxt = POS_NAME;
                v   = V_OK;
            end
            else if (ch == CH_STAR || ch == CH_SLASH)
            begin
                nxt = POS_EOL;
                v   = V_OK;
            end
            else if (ch == CH_NL)
                v = V_MATCH;
        end
        else if (line_pos == POS_EOL)
        begin
            if (ch == CH_NL)
                v = V_MATCH;
        end
        line_pos = nxt;
        return v;
    endfunction

    // Send one byte; called and returns at a rising edge. Valid stays high
    // after the transaction so back-to-back bytes need no toggle.
    task automatic send_byte(input logic [7:0] ch);
        int gap;
        if (src_idle && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 12);
            src_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        src_valid <= 1'b1;
        byte_in   <= ch;
        // ready sampled mid-cycle, where all inputs have settled
        @(negedge clk);
        while (!src_ready)
        begin
            @(posedge clk);
            @(negedge clk);
        end
        pending_verdicts.push_back(parse_char(ch));
        bytes_sent++;
        @(posedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // Result side: random stall bursts while rcv_idle is set
    initial
    begin
        int hold;
        hold = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold == 0 && rcv_idle && $urandom_range(0, 5) == 0)
                hold = $urandom_range(1, 12);
            res_ready <= (hold == 0);
            if (hold > 0)
                hold--;
        end
    end

    // Verdict check; a transaction seen mid-cycle completes at the next edge
    always @(negedge clk)
    begin
        if (rst_n && res_valid && res_ready)
        begin
            verdicts_seen++;
            if (verdict == V_MATCH)
                lines_matched++;
            if (verdict == V_REJ)
                lines_rejected++;
            if (pending_verdicts.size() == 0)
            begin
                $error("verdict: expected none, actual %0d", verdict);
                error_count++;
            end
            else
            begin
                if (verdict !== pending_verdicts[0])
                begin
                    $error("verdict: expected %0d, actual %0d", pending_verdicts[0], verdict);
                    error_count++;
                end
                void'(pending_verdicts.pop_front());
            end
        end
    end

    // Extreme byte values at the type and permission positions
    task automatic test_extremes();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_DASH);
        send_byte(8'h80);
    endtask

    // Name right after the blanks: no size field
    task automatic test_missing_size();
        send_text("c---------  z");
    endtask

    // Zero size followed by another digit
    task automatic test_zero_then_digit();
        send_text("b---------\t05");
    endtask

    // Random lines: mostly well formed, some with one corrupted byte, some noise
    task automatic test_random_lines(input int budget, input bit with_idle);
        logic [7:0] line[$];
        int         first;
        int         kind;
        int         n;
        first = bytes_sent;
        while (bytes_sent - first < budget)
        begin
            src_idle = with_idle && ($urandom_range(0, 3) != 0);
            rcv_idle = with_idle && ($urandom_range(0, 3) != 0);
            line.delete();
            kind = $urandom_range(0, 19);
            if (kind >= 17)
            begin
                n = $urandom_range(1, 6);
                repeat (n) line.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                case ($urandom_range(0, 6))
                    0:       line.push_back(CH_D_LO);
                    1:       line.push_back(CH_D_UP);
                    2:       line.push_back(CH_B);
                    3:       line.push_back(CH_C);
                    4:       line.push_back(CH_P);
                    5:       line.push_back(CH_S);
                    default: line.push_back(CH_DASH);
                endcase
                for (int i = 0; i < 9; i++)
                begin
                    if ($urandom_range(0, 1))
                        line.push_back(CH_DASH);
                    else
                        line.push_back((i % 3 == 0) ? CH_R : (i % 3 == 1) ? CH_W : CH_X);
                end
                n = $urandom_range(1, 3);
                repeat (n) line.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
                // size: zero alone, or digits without a leading zero
                if ($urandom_range(0, 3) == 0)
                    line.push_back(CH_ZERO);
                else
                begin
                    line.push_back(8'(CH_ZERO + $urandom_range(1, 9)));
                    n = $urandom_range(0, 5);
                    repeat (n) line.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
                end
                n = $urandom_range(1, 3);
                repeat (n) line.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
                n = $urandom_range(1, 9);
                for (int i = 0; i < n; i++)
                begin
                    case ($urandom_range((i == 0) ? 1 : 0, 4))
                        0:       line.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
                        1:       line.push_back(8'(CH_A_UP + $urandom_range(0, 25)));
                        2:       line.push_back(8'(CH_A_LO + $urandom_range(0, 25)));
                        3:       line.push_back(CH_DOT);
                        default: line.push_back(CH_UNDER);
                    endcase
                end
                case ($urandom_range(0, 3))
                    0:       line.push_back(CH_STAR);
                    1:       line.push_back(CH_SLASH);
                    default: ;
                endcase
                line.push_back(CH_NL);
                if (kind >= 12)
                    line[$urandom_range(0, line.size() - 1)] = 8'($urandom_range(0, 255));
            end
            foreach (line[i])
                send_byte(line[i]);
            // a newline from any position ends the line one way or the other
            if (line_pos != POS_TYPE)
                send_byte(CH_NL);
        end
    endtask

    // Sender holds off mid-line until every verdict is out, then finishes the line
    task automatic test_drain_pause();
        src_idle = 1'b1;
        rcv_idle = 1'b1;
        send_text("drwxr-xr-x 4");
        src_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        send_text("2 notes.txt\n");
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_missing_size();
        test_zero_then_digit();
        test_random_lines(700, 1'b1);
        test_drain_pause();
        test_random_lines(500, 1'b1);
        // last stretch at full rate on both sides
        src_idle = 1'b0;
        rcv_idle = 1'b0;
        test_random_lines(300, 1'b0);

        src_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("Sent %0d bytes and checked %0d verdicts.", bytes_sent, verdicts_seen);
        $display("Lines matched: %0d, rejections: %0d.", lines_matched, lines_rejected);
        if (error_count == 0 && pending_verdicts.size() == 0)
            $display("directory_listing_line_checker: match");
        else
            $display("directory_listing_line_checker: mismatch");
        $finish;
    end

endmodule

/* filelist.f */
rtl/dllc_pkg.sv
rtl/dllc_step.sv
rtl/directory_listing_line_checker.sv
tb/tb.sv
